FILE: rtl/avsc_pkg.sv
package avsc_pkg;

    localparam int COORD_W      = 12;
    localparam int CFG_W        = 13;
    localparam int ANG_W        = 12;
    localparam int OUT_W        = 17;
    localparam int SQ_IN_W      = 60;
    localparam int SQ_STEPS     = 30;
    localparam int REM_W        = 33;
    localparam int CORDIC_STEPS = 20;
    localparam int CX_W         = 37;
    localparam int Z_W          = 25;
    localparam int PHI_W        = 27;
    localparam int Q_W          = 17;

    // angles in 2^-16 degree
    localparam logic signed [PHI_W-1:0] DEG90  = 27'sd5898240;
    localparam logic signed [PHI_W-1:0] DEG180 = 27'sd11796480;
    localparam logic signed [PHI_W-1:0] DEG270 = 27'sd17694720;

    // angles in 1/256 degree
    localparam logic [Q_W-1:0] TURN_Q = 17'd92160;
    localparam logic [Q_W-1:0] HALF_Q = 17'd46080;

    // floor(2^29 / 45)
    localparam logic [23:0] RECIP45 = 24'd11930464;
    localparam logic [OUT_W-1:0] SAT_LIM = 17'd65536;

    typedef enum logic [2:0] {
        CFG_OUT_WIDTH   = 3'd0,
        CFG_OUT_HEIGHT  = 3'd1,
        CFG_PANO_WIDTH  = 3'd2,
        CFG_PANO_HEIGHT = 3'd3,
        CFG_FOV_ANGLE   = 3'd4,
        CFG_BLIND_ANGLE = 3'd5,
        CFG_LOOK_DOWN   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic ro_zero;
        logic inring;
        logic dxneg;
        logic dypos;
        logic axz;
        logic ayz;
    } t_flags;

    function automatic logic [22:0] atan_step(input int unsigned k);
        logic [22:0] v;
        case (k)
            0:       v = 23'd2949120;
            1:       v = 23'd1740967;
            2:       v = 23'd919879;
            3:       v = 23'd466945;
            4:       v = 23'd234379;
            5:       v = 23'd117304;
            6:       v = 23'd58666;
            7:       v = 23'd29335;
            8:       v = 23'd14668;
            9:       v = 23'd7334;
            10:      v = 23'd3667;
            11:      v = 23'd1833;
            12:      v = 23'd917;
            13:      v = 23'd458;
            14:      v = 23'd229;
            15:      v = 23'd115;
            16:      v = 23'd57;
            17:      v = 23'd29;
            18:      v = 23'd14;
            19:      v = 23'd7;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/annular_view_source_coordinate_top.sv
// Annular view source coordinate: maps an annular output pixel (i_col, i_row)
// to the equirectangular panorama position to sample.
// Input: raise start with i_col/i_row; the item is taken at any edge where
// start is high and busy is low. busy stays low: one item per clock.
// Output: o_done is high for one cycle with o_valid_res, o_src_x, o_src_y
// (4 fraction bits, saturated). Pixels outside the ring give o_valid_res 0
// and zero coordinates. Results come out in input order.
// Throughput one item per cycle. Items pass through the front end, the
// 30-stage square-root pipeline (CORDIC runs beside it), the 17-stage
// divider and the back end.
// There is no backpressure: the receiver must take every result as it comes.
// Configuration: write i_cfg_data to register i_cfg_addr with i_cfg_we,
// only while no item is in flight. Reset clears the pipeline valid bits and
// loads the default geometry (640x640 ring, 1280x640 panorama).
module annular_view_source_coordinate_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [avsc_pkg::COORD_W-1:0]  i_col,
    input  logic [avsc_pkg::COORD_W-1:0]  i_row,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_addr,
    input  logic [avsc_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                          o_done,
    output logic                          o_valid_res,
    output logic [avsc_pkg::OUT_W-1:0]    o_src_x,
    output logic [avsc_pkg::OUT_W-1:0]    o_src_y
);
    import avsc_pkg::*;

    logic [CFG_W-1:0] r_out_width, r_out_height, r_pano_width, r_pano_height;
    logic [ANG_W-1:0] r_fov_angle, r_blind_angle;
    logic             r_look_down;

    logic              f_vld;
    t_flags            f_flg;
    logic [CFG_W-1:0]  f_ro, f_ax, f_ay;
    logic [SQ_IN_W-1:0] f_n;

    logic               c_vld;
    t_flags             c_flg;
    logic [CFG_W-1:0]   c_ro;
    logic [SQ_STEPS-1:0] c_root;
    logic signed [Z_W-1:0] c_z;

    logic               d_vld;
    t_flags             d_flg;
    logic [Q_W-1:0]     d_q;
    logic signed [PHI_W-1:0] d_phi;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width   <= 13'd640;
            r_out_height  <= 13'd640;
            r_pano_width  <= 13'd1280;
            r_pano_height <= 13'd640;
            r_fov_angle   <= 12'd1920;
            r_blind_angle <= 12'd160;
            r_look_down   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_OUT_WIDTH:   r_out_width   <= i_cfg_data;
                CFG_OUT_HEIGHT:  r_out_height  <= i_cfg_data;
                CFG_PANO_WIDTH:  r_pano_width  <= i_cfg_data;
                CFG_PANO_HEIGHT: r_pano_height <= i_cfg_data;
                CFG_FOV_ANGLE:   r_fov_angle   <= i_cfg_data[ANG_W-1:0];
                CFG_BLIND_ANGLE: r_blind_angle <= i_cfg_data[ANG_W-1:0];
                CFG_LOOK_DOWN:   r_look_down   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    avsc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (start && !busy),
        .i_col         (i_col),
        .i_row         (i_row),
        .i_out_width   (r_out_width),
        .i_out_height  (r_out_height),
        .i_fov_angle   (r_fov_angle),
        .i_blind_angle (r_blind_angle),
        .o_vld         (f_vld),
        .o_flags       (f_flg),
        .o_ro          (f_ro),
        .o_ax          (f_ax),
        .o_ay          (f_ay),
        .o_n           (f_n)
    );

    avsc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_flags (f_flg),
        .i_ro    (f_ro),
        .i_ax    (f_ax),
        .i_ay    (f_ay),
        .i_n     (f_n),
        .o_vld   (c_vld),
        .o_flags (c_flg),
        .o_ro    (c_ro),
        .o_root  (c_root),
        .o_z     (c_z)
    );

    avsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (c_vld),
        .i_flags (c_flg),
        .i_ro    (c_ro),
        .i_root  (c_root),
        .i_z     (c_z),
        .o_vld   (d_vld),
        .o_flags (d_flg),
        .o_q     (d_q),
        .o_phi   (d_phi)
    );

    avsc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (d_vld),
        .i_flags       (d_flg),
        .i_q           (d_q),
        .i_phi         (d_phi),
        .i_pano_width  (r_pano_width),
        .i_pano_height (r_pano_height),
        .i_blind_angle (r_blind_angle),
        .i_look_down   (r_look_down),
        .o_done        (o_done),
        .o_valid_res   (o_valid_res),
        .o_src_x       (o_src_x),
        .o_src_y       (o_src_y)
    );

endmodule

FILE: rtl/avsc_front.sv
module avsc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [avsc_pkg::COORD_W-1:0]  i_col,
    input  logic [avsc_pkg::COORD_W-1:0]  i_row,
    input  logic [avsc_pkg::CFG_W-1:0]    i_out_width,
    input  logic [avsc_pkg::CFG_W-1:0]    i_out_height,
    input  logic [avsc_pkg::ANG_W-1:0]    i_fov_angle,
    input  logic [avsc_pkg::ANG_W-1:0]    i_blind_angle,
    output logic                          o_vld,
    output avsc_pkg::t_flags              o_flags,
    output logic [avsc_pkg::CFG_W-1:0]    o_ro,
    output logic [avsc_pkg::CFG_W-1:0]    o_ax,
    output logic [avsc_pkg::CFG_W-1:0]    o_ay,
    output logic [avsc_pkg::SQ_IN_W-1:0]  o_n
);
    import avsc_pkg::*;

    logic [5:0] r_vld;

    logic signed [14:0] n_dx, n_dy, n_rw, n_rh;
    logic signed [14:0] r1_dx, r1_dy, r1_ro;

    logic signed [14:0] w_adx, w_ady;
    logic [12:0] r2_ax, r2_ay, r2_ro;
    logic        r2_ro_neg;
    t_flags      r2_flg;

    logic [12:0] r3_ax, r3_ay, r3_ro;
    logic        r3_ro_neg;
    t_flags      r3_flg;
    logic [25:0] r3_dx2, r3_dy2, r3_ro2, r3_sum2;
    logic [23:0] r3_b2;
    logic [12:0] w_sum;

    logic [12:0] r4_ax, r4_ay, r4_ro;
    logic        r4_ro_neg;
    t_flags      r4_flg;
    logic [26:0] r4_d2;
    logic [25:0] r4_ro2, r4_sum2;
    logic [23:0] r4_b2;

    logic [12:0] r5_ax, r5_ay, r5_ro;
    t_flags      r5_flg;
    logic [52:0] r5_pa;
    logic [49:0] r5_pb;
    logic        r5_out;

    t_flags      n_flg;

    always_comb begin
        n_dx = $signed({2'b0, i_col, 1'b0}) - $signed({2'b0, i_out_width}) + 15'sd1;
        n_dy = $signed({2'b0, i_row, 1'b0}) - $signed({2'b0, i_out_height}) + 15'sd1;
        n_rw = $signed({2'b0, i_out_width}) - 15'sd1;
        n_rh = $signed({2'b0, i_out_height}) - 15'sd1;
    end

    assign w_adx = r1_dx[14] ? -r1_dx : r1_dx;
    assign w_ady = r1_dy[14] ? -r1_dy : r1_dy;
    assign w_sum = {1'b0, i_blind_angle} + {1'b0, i_fov_angle};

    always_comb begin
        n_flg = r5_flg;
        n_flg.inring = !r5_out && !(r5_pa < {3'b0, r5_pb});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        // offsets in half pixels from the image centre
        r1_dx <= n_dx;
        r1_dy <= n_dy;
        r1_ro <= (n_rh < n_rw) ? n_rh : n_rw;

        r2_ax          <= w_adx[12:0];
        r2_ay          <= w_ady[12:0];
        r2_ro          <= r1_ro[12:0];
        r2_ro_neg      <= r1_ro[14];
        r2_flg.ro_zero <= (r1_ro == 15'sd0);
        r2_flg.inring  <= 1'b0;
        r2_flg.dxneg   <= r1_dx[14];
        r2_flg.dypos   <= !r1_dy[14] && (r1_dy != 15'sd0);
        r2_flg.axz     <= (r1_dx == 15'sd0);
        r2_flg.ayz     <= (r1_dy == 15'sd0);

        r3_ax     <= r2_ax;
        r3_ay     <= r2_ay;
        r3_ro     <= r2_ro;
        r3_ro_neg <= r2_ro_neg;
        r3_flg    <= r2_flg;
        r3_dx2    <= 26'(r2_ax) * 26'(r2_ax);
        r3_dy2    <= 26'(r2_ay) * 26'(r2_ay);
        r3_ro2    <= 26'(r2_ro) * 26'(r2_ro);
        r3_sum2   <= 26'(w_sum) * 26'(w_sum);
        r3_b2     <= 24'(i_blind_angle) * 24'(i_blind_angle);

        r4_ax     <= r3_ax;
        r4_ay     <= r3_ay;
        r4_ro     <= r3_ro;
        r4_ro_neg <= r3_ro_neg;
        r4_flg    <= r3_flg;
        r4_d2     <= {1'b0, r3_dx2} + {1'b0, r3_dy2};
        r4_ro2    <= r3_ro2;
        r4_sum2   <= r3_sum2;
        r4_b2     <= r3_b2;

        r5_ax  <= r4_ax;
        r5_ay  <= r4_ay;
        r5_ro  <= r4_ro;
        r5_flg <= r4_flg;
        r5_pa  <= 53'(r4_d2) * 53'(r4_sum2);
        r5_pb  <= 50'(r4_ro2) * 50'(r4_b2);
        r5_out <= r4_ro_neg || (r4_d2 > {1'b0, r4_ro2});

        o_ax    <= r5_ax;
        o_ay    <= r5_ay;
        o_ro    <= r5_ro;
        o_flags <= n_flg;
        o_n     <= {r5_pa[51:0], 8'b0};
    end

    assign o_vld = r_vld[5];

endmodule

FILE: rtl/avsc_core.sv
module avsc_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  avsc_pkg::t_flags               i_flags,
    input  logic [avsc_pkg::CFG_W-1:0]     i_ro,
    input  logic [avsc_pkg::CFG_W-1:0]     i_ax,
    input  logic [avsc_pkg::CFG_W-1:0]     i_ay,
    input  logic [avsc_pkg::SQ_IN_W-1:0]   i_n,
    output logic                           o_vld,
    output avsc_pkg::t_flags               o_flags,
    output logic [avsc_pkg::CFG_W-1:0]     o_ro,
    output logic [avsc_pkg::SQ_STEPS-1:0]  o_root,
    output logic signed [avsc_pkg::Z_W-1:0] o_z
);
    import avsc_pkg::*;

    logic                    w_vld  [0:SQ_STEPS];
    t_flags                  w_flg  [0:SQ_STEPS];
    logic [CFG_W-1:0]        w_ro   [0:SQ_STEPS];
    logic [SQ_IN_W-1:0]      w_n    [0:SQ_STEPS];
    logic [REM_W-1:0]        w_rem  [0:SQ_STEPS];
    logic [SQ_STEPS-1:0]     w_root [0:SQ_STEPS];
    logic signed [CX_W-1:0]  w_x    [0:SQ_STEPS];
    logic signed [CX_W-1:0]  w_y    [0:SQ_STEPS];
    logic signed [Z_W-1:0]   w_z    [0:SQ_STEPS];

    assign w_vld[0]  = i_vld;
    assign w_flg[0]  = i_flags;
    assign w_ro[0]   = i_ro;
    assign w_n[0]    = i_n;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_x[0]    = $signed({4'b0, i_ax, 20'b0});
    assign w_y[0]    = $signed({4'b0, i_ay, 20'b0});
    assign w_z[0]    = '0;

    // one square-root digit per stage; the first stages also run one CORDIC rotation each
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
        logic                   r_vld;
        t_flags                 r_flg;
        logic [CFG_W-1:0]       r_ro;
        logic [SQ_IN_W-1:0]     r_n;
        logic [REM_W-1:0]       r_rem;
        logic [SQ_STEPS-1:0]    r_root;
        logic signed [CX_W-1:0] r_x, r_y;
        logic signed [Z_W-1:0]  r_z;

        logic [REM_W-1:0]       n_sh, n_trial, n_rem;
        logic                   n_ge;
        logic signed [CX_W-1:0] n_x, n_y;
        logic signed [Z_W-1:0]  n_z;

        always_comb begin
            n_sh    = {w_rem[k][REM_W-3:0], w_n[k][SQ_IN_W-1 -: 2]};
            n_trial = {1'b0, w_root[k], 2'b01};
            n_ge    = (n_sh >= n_trial);
            n_rem   = n_ge ? (n_sh - n_trial) : n_sh;
        end

        if (k < CORDIC_STEPS) begin : g_rot
            logic signed [Z_W-1:0] w_atan;
            assign w_atan = $signed({2'b0, atan_step(k)});
            always_comb begin
                if (!w_y[k][CX_W-1]) begin
                    n_x = w_x[k] + (w_y[k] >>> k);
                    n_y = w_y[k] - (w_x[k] >>> k);
                    n_z = w_z[k] + w_atan;
                end else begin
                    n_x = w_x[k] - (w_y[k] >>> k);
                    n_y = w_y[k] + (w_x[k] >>> k);
                    n_z = w_z[k] - w_atan;
                end
            end
        end else begin : g_hold
            always_comb begin
                n_x = w_x[k];
                n_y = w_y[k];
                n_z = w_z[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_flg  <= w_flg[k];
            r_ro   <= w_ro[k];
            r_n    <= {w_n[k][SQ_IN_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= {w_root[k][SQ_STEPS-2:0], n_ge};
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end

        assign w_vld[k+1]  = r_vld;
        assign w_flg[k+1]  = r_flg;
        assign w_ro[k+1]   = r_ro;
        assign w_n[k+1]    = r_n;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_x[k+1]    = r_x;
        assign w_y[k+1]    = r_y;
        assign w_z[k+1]    = r_z;
    end

    assign o_vld   = w_vld[SQ_STEPS];
    assign o_flags = w_flg[SQ_STEPS];
    assign o_ro    = w_ro[SQ_STEPS];
    assign o_root  = w_root[SQ_STEPS];
    assign o_z     = w_z[SQ_STEPS];

endmodule

FILE: rtl/avsc_div.sv
module avsc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  avsc_pkg::t_flags                i_flags,
    input  logic [avsc_pkg::CFG_W-1:0]      i_ro,
    input  logic [avsc_pkg::SQ_STEPS-1:0]   i_root,
    input  logic signed [avsc_pkg::Z_W-1:0] i_z,
    output logic                            o_vld,
    output avsc_pkg::t_flags                o_flags,
    output logic [avsc_pkg::Q_W-1:0]        o_q,
    output logic signed [avsc_pkg::PHI_W-1:0] o_phi
);
    import avsc_pkg::*;

    logic                    w_vld [0:Q_W];
    t_flags                  w_flg [0:Q_W];
    logic [CFG_W-1:0]        w_ro  [0:Q_W];
    logic [CFG_W-1:0]        w_rem [0:Q_W];
    logic [Q_W-1:0]          w_s   [0:Q_W];
    logic [Q_W-1:0]          w_q   [0:Q_W];
    logic signed [PHI_W-1:0] w_phi [0:Q_W];

    logic signed [PHI_W-1:0] n_zx, n_a, n_phi;

    // restore the quadrant of the first-quadrant CORDIC angle
    always_comb begin
        n_zx = PHI_W'(i_z);
        if (n_zx < 0) begin
            n_a = '0;
        end else if (n_zx > DEG90) begin
            n_a = DEG90;
        end else begin
            n_a = n_zx;
        end
        if (i_flags.ayz) begin
            n_phi = i_flags.dxneg ? DEG180 : '0;
        end else if (i_flags.axz) begin
            n_phi = i_flags.dypos ? DEG90 : -DEG90;
        end else if (!i_flags.dxneg) begin
            n_phi = i_flags.dypos ? n_a : -n_a;
        end else begin
            n_phi = i_flags.dypos ? (DEG180 - n_a) : (n_a - DEG180);
        end
    end

    assign w_vld[0] = i_vld;
    assign w_flg[0] = i_flags;
    assign w_ro[0]  = i_ro;
    assign w_rem[0] = i_root[SQ_STEPS-1:Q_W];
    assign w_s[0]   = i_root[Q_W-1:0];
    assign w_q[0]   = '0;
    assign w_phi[0] = n_phi;

    // one quotient bit per stage
    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic                    r_vld;
        t_flags                  r_flg;
        logic [CFG_W-1:0]        r_ro, r_rem;
        logic [Q_W-1:0]          r_s, r_q;
        logic signed [PHI_W-1:0] r_phi;

        logic [CFG_W:0]          n_r, n_d;
        logic                    n_ge;

        always_comb begin
            n_r  = {w_rem[k], w_s[k][Q_W-1]};
            n_d  = {1'b0, w_ro[k]};
            n_ge = (n_r >= n_d);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_flg <= w_flg[k];
            r_ro  <= w_ro[k];
            r_rem <= n_ge ? CFG_W'(n_r - n_d) : n_r[CFG_W-1:0];
            r_s   <= {w_s[k][Q_W-2:0], 1'b0};
            r_q   <= {w_q[k][Q_W-2:0], n_ge};
            r_phi <= w_phi[k];
        end

        assign w_vld[k+1] = r_vld;
        assign w_flg[k+1] = r_flg;
        assign w_ro[k+1]  = r_ro;
        assign w_rem[k+1] = r_rem;
        assign w_s[k+1]   = r_s;
        assign w_q[k+1]   = r_q;
        assign w_phi[k+1] = r_phi;
    end

    assign o_vld   = w_vld[Q_W];
    assign o_flags = w_flg[Q_W];
    assign o_q     = w_q[Q_W];
    assign o_phi   = w_phi[Q_W];

endmodule

FILE: rtl/avsc_back.sv
module avsc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  avsc_pkg::t_flags                  i_flags,
    input  logic [avsc_pkg::Q_W-1:0]          i_q,
    input  logic signed [avsc_pkg::PHI_W-1:0] i_phi,
    input  logic [avsc_pkg::CFG_W-1:0]        i_pano_width,
    input  logic [avsc_pkg::CFG_W-1:0]        i_pano_height,
    input  logic [avsc_pkg::ANG_W-1:0]        i_blind_angle,
    input  logic                              i_look_down,
    output logic                              o_done,
    output logic                              o_valid_res,
    output logic [avsc_pkg::OUT_W-1:0]        o_src_x,
    output logic [avsc_pkg::OUT_W-1:0]        o_src_y
);
    import avsc_pkg::*;

    logic [4:0] r_vld;
    logic [4:0] r_inr;

    logic [Q_W-1:0]          n_t, n_tm;
    logic [Q_W-1:0]          r1_tm;
    logic                    r1_up;
    logic signed [PHI_W-1:0] r1_phi;

    logic signed [PHI_W-1:0] n_tmd, n_el, n_az, n_nx, n_ny;
    logic [24:0]             r2_nx;
    logic [23:0]             r2_ny;

    logic [37:0]             r3_vx;
    logic [36:0]             r3_vy;

    logic [41:0]             w_sx;
    logic [40:0]             w_sy;
    logic [22:0]             r4_xx, r4_yy;

    logic [22:0]             r5_xx, r5_yy;
    logic [46:0]             r5_mx, r5_my;

    logic [17:0]             w_q0x, w_q0y, w_qx, w_qy;
    logic [23:0]             w_rx, w_ry;

    // theta in 1/256 degree, folded into one turn
    always_comb begin
        n_t  = i_flags.ro_zero ? {1'b0, i_blind_angle, 4'b0} : i_q;
        n_tm = (n_t >= TURN_Q) ? (n_t - TURN_Q) : n_t;
    end

    always_comb begin
        n_tmd = $signed({2'b0, r1_tm, 8'b0});
        if (r1_up) begin
            n_el = DEG90 - n_tmd;
            n_az = r1_phi;
        end else begin
            n_el = n_tmd - DEG270;
            n_az = (r1_phi > 0) ? (r1_phi - DEG180) : (r1_phi + DEG180);
        end
        if (i_look_down) begin
            n_nx = DEG180 + n_az;
            n_ny = DEG90 + n_el;
        end else begin
            n_nx = DEG180 - n_az;
            n_ny = DEG90 - n_el;
        end
    end

    // add half the divisor, then drop its power-of-two part
    assign w_sx = {r3_vx, 4'b0} + 42'd11796480;
    assign w_sy = {r3_vy, 4'b0} + 41'd5898240;

    // reciprocal estimate is low by at most one; fix it with one compare
    always_comb begin
        w_q0x = r5_mx[46:29];
        w_q0y = r5_my[46:29];
        w_rx  = {1'b0, r5_xx} - ({6'b0, w_q0x} * 24'd45);
        w_ry  = {1'b0, r5_yy} - ({6'b0, w_q0y} * 24'd45);
        w_qx  = w_q0x + {17'b0, (w_rx >= 24'd45)};
        w_qy  = w_q0y + {17'b0, (w_ry >= 24'd45)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            o_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[3:0], i_vld};
            o_done <= r_vld[4];
        end
    end

    always_ff @(posedge i_clk) begin
        r_inr  <= {r_inr[3:0], i_flags.inring};
        r1_tm  <= n_tm;
        r1_up  <= (n_tm <= HALF_Q);
        r1_phi <= i_phi;

        r2_nx <= n_nx[24:0];
        r2_ny <= n_ny[23:0];

        r3_vx <= 38'(i_pano_width) * 38'(r2_nx);
        r3_vy <= 37'(i_pano_height) * 37'(r2_ny);

        r4_xx <= w_sx[41:19];
        r4_yy <= w_sy[40:18];

        r5_xx <= r4_xx;
        r5_yy <= r4_yy;
        r5_mx <= 47'(r4_xx) * 47'(RECIP45);
        r5_my <= 47'(r4_yy) * 47'(RECIP45);

        o_valid_res <= r_inr[4];
        if (!r_inr[4]) begin
            o_src_x <= '0;
            o_src_y <= '0;
        end else begin
            o_src_x <= (w_qx > 18'(SAT_LIM)) ? SAT_LIM : w_qx[OUT_W-1:0];
            o_src_y <= (w_qy > 18'(SAT_LIM)) ? SAT_LIM : w_qy[OUT_W-1:0];
        end
    end

`ifndef ASSERT_OFF
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result strobe after reset");
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_valid_res |-> o_src_x == '0 && o_src_y == '0)
        else $error("nonzero coordinate on pixel outside ring");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_src_x <= SAT_LIM && o_src_y <= SAT_LIM)
        else $error("coordinate above saturation limit");
    a_recip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> w_rx < 24'd90 && w_ry < 24'd90)
        else $error("reciprocal quotient off by more than one");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import avsc_pkg::*;

    localparam int PIPE_LAT  = 59;
    localparam int WDOG_LIM  = 20000;
    localparam int N_RANDOM  = 400;
    localparam int MAX_SHOW  = 10;

    typedef struct {
        logic             vres;
        logic [OUT_W-1:0] sx;
        logic [OUT_W-1:0] sy;
    } t_coord;

    typedef struct {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        bit                 typed;
        t_coord             exp_res;
    } t_vec;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [COORD_W-1:0] i_col = '0;
    logic [COORD_W-1:0] i_row = '0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_addr = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               o_done;
    logic               o_valid_res;
    logic [OUT_W-1:0]   o_src_x;
    logic [OUT_W-1:0]   o_src_y;

    // shadow geometry
    logic [12:0] g_ow, g_oh, g_pw, g_ph;
    logic [11:0] g_fov, g_blind;
    logic        g_down;

    t_coord pending_coords[$];
    int     mismatch_cnt = 0;
    int     pixels_sent = 0;
    int     pixels_checked = 0;
    int     ring_hits = 0;
    int     idle_cycles = 0;
    bit     timed_out = 1'b0;

    always #10 i_clk = ~i_clk;

    annular_view_source_coordinate_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_valid_res (o_valid_res),
        .o_src_x     (o_src_x),
        .o_src_y     (o_src_y)
    );

    function automatic longint shr_floor(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= r + bt) begin
                n -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic longint first_quadrant_angle(longint ax, longint ay);
        longint x, y, z, nx;
        x = ax * 1048576;
        y = ay * 1048576;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + shr_floor(y, i);
                y  = y - shr_floor(x, i);
                z += longint'(atan_step(i));
            end else begin
                nx = x - shr_floor(y, i);
                y  = y + shr_floor(x, i);
                z -= longint'(atan_step(i));
            end
            x = nx;
        end
        if (z < 0) z = 0;
        if (z > longint'(DEG90)) z = longint'(DEG90);
        return z;
    endfunction

    function automatic logic [OUT_W-1:0] scale_clip(longint unsigned sz, longint unsigned num,
                                                    longint unsigned den);
        longint unsigned v;
        v = ((sz * num << 4) + den / 2) / den;
        return (v > 65536) ? OUT_W'(65536) : OUT_W'(v);
    endfunction

    function automatic t_coord source_coord(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
        t_coord r;
        longint dx, dy, ro, ax, ay, phi, theta, tm, az, el, a;
        longint d90, d180, d270, d360;
        longint unsigned d2, sum, b;
        d90  = longint'(DEG90);
        d180 = longint'(DEG180);
        d270 = longint'(DEG270);
        d360 = 2 * d180;
        r = '{1'b0, '0, '0};
        dx = 2 * longint'(col) - (longint'(g_ow) - 1);
        dy = 2 * longint'(row) - (longint'(g_oh) - 1);
        ro = longint'(g_ow) - 1;
        if (longint'(g_oh) - 1 < ro) ro = longint'(g_oh) - 1;
        d2  = longint'(dx * dx + dy * dy);
        sum = longint'(g_blind) + longint'(g_fov);
        b   = g_blind;
        if (ro < 0 || d2 > longint'(ro * ro)) return r;
        if (d2 * sum * sum < longint'(ro * ro) * b * b) return r;
        if (ro == 0) theta = longint'(b) * 4096;
        else theta = longint'(int_sqrt(sum * sum * d2 * 256) / longint'(ro)) * 256;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ay == 0) phi = dx < 0 ? d180 : 0;
        else if (ax == 0) phi = dy > 0 ? d90 : -d90;
        else begin
            a = first_quadrant_angle(ax, ay);
            if (dx > 0) phi = dy > 0 ? a : -a;
            else phi = dy > 0 ? d180 - a : a - d180;
        end
        tm = theta % d360;
        if (tm <= d180) begin
            el = d90 - tm;
            az = phi;
        end else begin
            el = tm - d270;
            az = phi > 0 ? phi - d180 : phi + d180;
        end
        if (g_down) begin
            az = -az;
            el = -el;
        end
        r.vres = 1'b1;
        r.sx = scale_clip(g_pw, longint'(d180 - az), d360);
        r.sy = scale_clip(g_ph, longint'(d90 - el), d180);
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        case (idx)
            CFG_OUT_WIDTH:   g_ow    = 13'(val);
            CFG_OUT_HEIGHT:  g_oh    = 13'(val);
            CFG_PANO_WIDTH:  g_pw    = 13'(val);
            CFG_PANO_HEIGHT: g_ph    = 13'(val);
            CFG_FOV_ANGLE:   g_fov   = 12'(val);
            CFG_BLIND_ANGLE: g_blind = 12'(val);
            CFG_LOOK_DOWN:   g_down  = 1'(val);
            default: ;
        endcase
    endtask

    task automatic set_geometry(int ow, int oh, int pw, int ph, int fov, int blind, int down);
        write_reg(CFG_OUT_WIDTH, ow);
        write_reg(CFG_OUT_HEIGHT, oh);
        write_reg(CFG_PANO_WIDTH, pw);
        write_reg(CFG_PANO_HEIGHT, ph);
        write_reg(CFG_FOV_ANGLE, fov);
        write_reg(CFG_BLIND_ANGLE, blind);
        write_reg(CFG_LOOK_DOWN, down);
        i_cfg_we <= 1'b0;
    endtask

    // drive one item and wait for its accepting edge; the caller drops start
    task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
        start <= 1'b1;
        i_col <= col;
        i_row <= row;
        do @(posedge i_clk); while (busy);
        pending_coords.push_back(source_coord(col, row));
        pixels_sent++;
    endtask

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
        if (g != 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (pending_coords.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    // mostly pixels inside the current image, the rest anywhere in the coordinate range
    task automatic random_burst(int n);
        logic [COORD_W-1:0] c, r;
        bit hold;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                c = COORD_W'($urandom);
                r = COORD_W'($urandom);
            end else begin
                c = COORD_W'($urandom_range(0, (g_ow > 1) ? g_ow - 1 : 0));
                r = COORD_W'($urandom_range(0, (g_oh > 1) ? g_oh - 1 : 0));
            end
            hold = ($urandom_range(0, 3) != 0) && (k != n - 1);
            send_pixel(c, r);
            if (!hold) random_gap();
        end
        start <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_coord exp_c;
        if (i_rst_n && o_done) begin
            if (pending_coords.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_SHOW)
                    $display("unexpected item: valid=%0d x=%0d y=%0d",
                             o_valid_res, o_src_x, o_src_y);
            end else begin
                exp_c = pending_coords.pop_front();
                pixels_checked++;
                if (exp_c.vres) ring_hits++;
                if (o_valid_res !== exp_c.vres || o_src_x !== exp_c.sx
                        || o_src_y !== exp_c.sy) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_SHOW)
                        $display("mismatch: exp valid=%0d x=%0d y=%0d got valid=%0d x=%0d y=%0d",
                                 exp_c.vres, exp_c.sx, exp_c.sy,
                                 o_valid_res, o_src_x, o_src_y);
                end
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WDOG_LIM) begin
                timed_out = 1'b1;
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        t_vec vecs[$];
        t_coord got;
        g_ow = 640; g_oh = 640; g_pw = 1280; g_ph = 640;
        g_fov = 1920; g_blind = 160; g_down = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: centre sits in the blind spot, corners outside
        vecs.push_back('{12'd0,    12'd0,    1'b1, '{1'b0, '0, '0}});
        vecs.push_back('{12'd4095, 12'd4095, 1'b1, '{1'b0, '0, '0}});
        vecs.push_back('{12'd319,  12'd320,  1'b1, '{1'b0, '0, '0}});
        vecs.push_back('{12'd639,  12'd319,  1'b0, '{1'b0, '0, '0}});
        vecs.push_back('{12'd0,    12'd320,  1'b0, '{1'b0, '0, '0}});
        vecs.push_back('{12'd320,  12'd639,  1'b0, '{1'b0, '0, '0}});
        vecs.push_back('{12'd320,  12'd0,    1'b0, '{1'b0, '0, '0}});
        vecs.push_back('{12'd500,  12'd100,  1'b0, '{1'b0, '0, '0}});
        vecs.push_back('{12'd100,  12'd500,  1'b0, '{1'b0, '0, '0}});
        vecs.push_back('{12'd100,  12'd100,  1'b0, '{1'b0, '0, '0}});
        vecs.push_back('{12'd2730, 12'd1365, 1'b1, '{1'b0, '0, '0}});
        foreach (vecs[i]) begin
            send_pixel(vecs[i].col, vecs[i].row);
            if (vecs[i].typed) begin
                got = pending_coords[$];
                if (got.vres !== vecs[i].exp_res.vres) begin
                    mismatch_cnt++;
                    $display("model disagrees with table row %0d", i);
                end
            end
        end
        start <= 1'b0;
        drain();

        // centre-only ring: 1x1 image, theta is the blind angle
        set_geometry(1, 1, 4095, 4095, 2880, 2880, 1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        start <= 1'b0;
        drain();
        // zero sizes and zero angles
        set_geometry(0, 0, 0, 0, 0, 0, 0);
        send_pixel(12'd0, 12'd0);
        start <= 1'b0;
        drain();
        set_geometry(3, 3, 1, 1, 0, 0, 0);
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++) send_pixel(12'(c), 12'(r));
        start <= 1'b0;
        drain();

        // random phases over several geometries, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_geometry(640, 640, 1280, 640, 1920, 160, 0);
                1: set_geometry(4096, 4096, 4096, 4096, 2880, 0, 1);
                2: set_geometry(8191, 8191, 8191, 8191, 4095, 4095, 0);
                3: set_geometry(17, 33, 1, 1, 1, 2880, 1);
                4: set_geometry(4095, 2, 3000, 2000, 2880, 2880, 0);
                default: set_geometry($urandom_range(1, 4096), $urandom_range(1, 4096),
                                      $urandom_range(1, 4096), $urandom_range(1, 4096),
                                      $urandom_range(1, 4095), $urandom_range(0, 4095),
                                      $urandom_range(0, 1));
            endcase
            random_burst(N_RANDOM / 8);
            drain();
        end

        $display("sent %0d pixels over 11 geometries, %0d results checked, %0d inside the ring",
                 pixels_sent, pixels_checked, ring_hits);
        if (mismatch_cnt == 0 && pending_coords.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_cnt,
                     pending_coords.size());
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/avsc_pkg.sv
rtl/avsc_front.sv
rtl/avsc_core.sv
rtl/avsc_div.sv
rtl/avsc_back.sv
rtl/annular_view_source_coordinate_top.sv
dv/tb_top.sv
